### design/hsd_pkg.sv
// Shared types and codes for the Huffman stream decoder.
// No dependencies.
package hsd_pkg;

	// Command codes passed from the header parser to the decoder
	typedef enum logic [1:0] {
		CMD_ENTRY = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_ERR   = 2'd2
	} cmd_op_t;

	// Result kinds
	localparam logic [1:0] KIND_SYM = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
		logic       last;
	} hsd_res_t;

	localparam int RES_W = $bits(hsd_res_t);

endpackage

### design/huffman_stream_decoder.sv
// Huffman stream decoder top level: header parser, command queue, decoder, result queue.
// Depends on hsd_pkg, hsd_queue, hsd_front, hsd_back.
//
//   channel  | handshake        | fields
//   ---------+------------------+--------------------
//   input    | push / full      | data_byte
//   result   | empty / pop      | kind, symbol, last
//
// Header bytes are taken back to back while the command queue has room. A payload byte
// is handled as a command pop, then, for each of its 8 bits, a bit step and a table
// match that walks the stored entries in order through the single read port of the
// entry memory, then a final flush. Bytes after an end or error are dropped.
// Reset clears all control state; the entry memory needs no clearing pass.
// A full result queue stalls the decoder; the command queue lets header and
// payload bytes keep arriving meanwhile, until it fills.
module huffman_stream_decoder #(
	parameter int TABLE_ENTRIES = 512,
	parameter int MAX_CODE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] kind,
	output logic [7:0] symbol,
	output logic       last
);
	import hsd_pkg::*;

	localparam int CMD_W = 2 + 1 + 8 + $clog2(MAX_CODE_BITS + 1) + MAX_CODE_BITS;

	logic             cmd_push;
	logic [CMD_W-1:0] cmd_din;
	logic             cmd_full;
	logic             cmd_pop;
	logic [CMD_W-1:0] cmd_dout;
	logic             cmd_empty;
	logic             res_push;
	hsd_res_t         res_din;
	logic             res_full;
	logic [RES_W-1:0] res_dout;
	hsd_res_t         res;

	assign full = cmd_full;

	hsd_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS), .CMD_W(CMD_W))
	u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push), .in_byte(data_byte),
		.cmd_full(cmd_full), .cmd_push(cmd_push), .cmd_din(cmd_din)
	);

	hsd_queue #(.WIDTH(CMD_W), .DEPTH(2)) u_cmdq (
		.clk(clk), .arst_n(arst_n), .push(cmd_push), .din(cmd_din), .full(cmd_full),
		.pop(cmd_pop), .dout(cmd_dout), .empty(cmd_empty)
	);

	hsd_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS), .CMD_W(CMD_W))
	u_back (
		.clk(clk), .arst_n(arst_n), .cmd_empty(cmd_empty), .cmd_dout(cmd_dout),
		.cmd_pop(cmd_pop), .res_full(res_full), .res_push(res_push), .res_din(res_din)
	);

	hsd_queue #(.WIDTH(RES_W), .DEPTH(2)) u_resq (
		.clk(clk), .arst_n(arst_n), .push(res_push), .din(res_din), .full(res_full),
		.pop(pop), .dout(res_dout), .empty(empty)
	);

	assign res    = hsd_res_t'(res_dout);
	assign kind   = res.kind;
	assign symbol = res.symbol;
	assign last   = res.last;
endmodule

### design/hsd_queue.sv
// Small first-in first-out queue of generic width.
// No dependencies.
module hsd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= din;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

### design/hsd_front.sv
// Header parser: takes file bytes, assembles table entries, forwards payload bytes.
// Depends on hsd_pkg.
module hsd_front #(
	parameter int TABLE_ENTRIES = 512,
	parameter int MAX_CODE_BITS = 32,
	parameter int CMD_W = 2 + 1 + 8 + $clog2(MAX_CODE_BITS + 1) + MAX_CODE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             cmd_full,
	output logic             cmd_push,
	output logic [CMD_W-1:0] cmd_din
);
	import hsd_pkg::*;

	localparam int LW = $clog2(MAX_CODE_BITS + 1);
	localparam int CW = MAX_CODE_BITS;

	typedef enum logic [3:0] {
		PH_CNT_LO, PH_CNT_HI, PH_MARK0, PH_MARK1, PH_SYM,
		PH_LEN_LO, PH_LEN_HI, PH_CODE, PH_DATA, PH_HALT
	} phase_t;

	phase_t        phase_q;
	logic [15:0]   left_q;
	logic [7:0]    len_lo_q;
	logic [15:0]   flen_q;
	logic [15:0]   loaded_q;
	logic [7:0]    sym_q;
	logic [CW-1:0] code_q;
	logic          is_end_q;

	logic          take;
	logic [15:0]   flen_new;
	logic [CW-1:0] code_new;
	logic [16:0]   loaded_nxt;
	logic          code_done;
	cmd_op_t       op;
	logic          emit;
	logic [CW-1:0] emit_code;

	assign take       = in_valid && !cmd_full;
	assign flen_new   = {in_byte, len_lo_q};
	assign loaded_nxt = {1'b0, loaded_q} + 17'd8;
	assign code_done  = loaded_nxt >= {1'b0, flen_q};

	// place the code byte at its position, dropping bits past the length
	always_comb begin
		code_new = code_q;
		for (int i = 0; i < CW; i++) begin
			if ((16'(i) >> 3) == (loaded_q >> 3) && 16'(i) < flen_q)
				code_new[i] = in_byte[i % 8];
		end
	end

	// command decode for the current byte
	always_comb begin
		op        = CMD_DATA;
		emit      = 1'b0;
		emit_code = code_new;
		case (phase_q)
			PH_MARK0: begin
				if (in_byte != 8'd0) begin
					op   = CMD_ERR;
					emit = 1'b1;
				end
			end
			PH_MARK1: begin
				if (in_byte != 8'd1 || left_q == '0 ||
						{1'b0, left_q} > 17'(TABLE_ENTRIES)) begin
					op   = CMD_ERR;
					emit = 1'b1;
				end
			end
			PH_LEN_HI: begin
				if ({1'b0, flen_new} > 17'(MAX_CODE_BITS)) begin
					op   = CMD_ERR;
					emit = 1'b1;
				end else if (flen_new == '0) begin
					op        = CMD_ENTRY;
					emit      = 1'b1;
					emit_code = '0;
				end
			end
			PH_CODE: begin
				if (code_done) begin
					op   = CMD_ENTRY;
					emit = 1'b1;
				end
			end
			PH_DATA: begin
				op   = CMD_DATA;
				emit = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign cmd_push = take && emit;
	assign cmd_din  = {op, is_end_q, (op == CMD_DATA) ? in_byte : (is_end_q ? 8'd0 : sym_q),
		(phase_q == PH_LEN_HI) ? LW'(flen_new) : LW'(flen_q), emit_code};

	// header state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CNT_LO;
			left_q   <= '0;
			len_lo_q <= '0;
			flen_q   <= '0;
			loaded_q <= '0;
			sym_q    <= '0;
			code_q   <= '0;
			is_end_q <= 1'b1;
		end else if (take) begin
			case (phase_q)
				PH_CNT_LO: begin
					left_q  <= {8'd0, in_byte};
					phase_q <= PH_CNT_HI;
				end
				PH_CNT_HI: begin
					left_q  <= {in_byte, left_q[7:0]};
					phase_q <= PH_MARK0;
				end
				PH_MARK0: begin
					phase_q <= emit ? PH_HALT : PH_MARK1;
				end
				PH_MARK1: begin
					phase_q <= emit ? PH_HALT : PH_LEN_LO;
				end
				PH_SYM: begin
					sym_q   <= in_byte;
					phase_q <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_lo_q <= in_byte;
					phase_q  <= PH_LEN_HI;
				end
				PH_LEN_HI: begin
					flen_q   <= flen_new;
					code_q   <= '0;
					loaded_q <= '0;
					if (op == CMD_ERR) begin
						phase_q <= PH_HALT;
					end else if (emit) begin
						is_end_q <= 1'b0;
						left_q   <= left_q - 16'd1;
						phase_q  <= (left_q == 16'd1) ? PH_DATA : PH_SYM;
					end else begin
						phase_q <= PH_CODE;
					end
				end
				PH_CODE: begin
					code_q   <= code_new;
					loaded_q <= loaded_nxt[15:0];
					if (code_done) begin
						is_end_q <= 1'b0;
						left_q   <= left_q - 16'd1;
						phase_q  <= (left_q == 16'd1) ? PH_DATA : PH_SYM;
					end
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end
	end
endmodule

### design/hsd_back.sv
// Decoder: stores table entries and matches payload bits against the table.
// Depends on hsd_pkg.
module hsd_back #(
	parameter int TABLE_ENTRIES = 512,
	parameter int MAX_CODE_BITS = 32,
	parameter int CMD_W = 2 + 1 + 8 + $clog2(MAX_CODE_BITS + 1) + MAX_CODE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  logic [CMD_W-1:0] cmd_dout,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output hsd_pkg::hsd_res_t res_din
);
	import hsd_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int LW = $clog2(MAX_CODE_BITS + 1);
	localparam int BW = $clog2(MAX_CODE_BITS);
	localparam int CW = MAX_CODE_BITS;
	localparam int EW = 1 + 8 + LW + CW;

	typedef enum logic [2:0] {S_IDLE, S_BIT, S_READ, S_CMP, S_FLUSH} state_t;

	logic [EW-1:0] mem [TABLE_ENTRIES];
	logic [EW-1:0] rd_q;

	state_t        state_q;
	logic [AW:0]   fill_q;
	logic [AW-1:0] k_q;
	logic [2:0]    j_q;
	logic [7:0]    byte_q;
	logic [CW-1:0] acc_code_q;
	logic [LW-1:0] acc_len_q;
	logic          halted_q;
	logic          pend_v_q;
	hsd_res_t      pend_q;

	cmd_op_t       op;
	logic [7:0]    cmd_byte;
	logic          we;
	logic          hit;
	logic          overflow;
	logic          event_v;
	logic [1:0]    event_kind;
	logic          can_post;

	assign op       = cmd_op_t'(cmd_dout[CMD_W-1 -: 2]);
	assign cmd_byte = cmd_dout[CW+LW +: 8];
	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign we       = cmd_pop && op == CMD_ENTRY && fill_q < (AW+1)'(TABLE_ENTRIES);

	// entry store, registered read
	always_ff @(posedge clk) begin
		if (we) mem[fill_q[AW-1:0]] <= cmd_dout[EW-1:0];
		rd_q <= mem[k_q];
	end

	assign hit = (rd_q[CW +: LW] == acc_len_q) && (rd_q[CW-1:0] == acc_code_q);
	assign overflow = (acc_len_q == LW'(MAX_CODE_BITS));
	assign event_v = (state_q == S_CMP && hit) || (state_q == S_BIT && overflow);
	assign event_kind = (state_q == S_BIT) ? KIND_ERR : (rd_q[EW-1] ? KIND_END : KIND_SYM);
	assign can_post = !pend_v_q || !res_full;

	// result push: a held result goes out once the next one or the byte end is known
	always_comb begin
		res_push = 1'b0;
		res_din  = pend_q;
		if (state_q == S_FLUSH) begin
			res_push     = pend_v_q && !res_full;
			res_din.last = 1'b1;
		end else if (event_v) begin
			res_push     = pend_v_q && !res_full;
			res_din.last = 1'b0;
		end
	end

	// bit-serial decode sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			k_q        <= '0;
			j_q        <= '0;
			byte_q     <= '0;
			acc_code_q <= '0;
			acc_len_q  <= '0;
			halted_q   <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						if (we) fill_q <= fill_q + 1'b1;
						if (op == CMD_DATA && !halted_q) begin
							byte_q  <= cmd_byte;
							j_q     <= '0;
							state_q <= S_BIT;
						end else if (op == CMD_ERR && !halted_q) begin
							pend_v_q <= 1'b1;
							pend_q   <= '{kind: KIND_ERR, symbol: 8'd0, last: 1'b0};
							halted_q <= 1'b1;
							state_q  <= S_FLUSH;
						end
					end
				end
				S_BIT: begin
					if (overflow) begin
						if (can_post) begin
							pend_v_q <= 1'b1;
							pend_q   <= '{kind: KIND_ERR, symbol: 8'd0, last: 1'b0};
							halted_q <= 1'b1;
							state_q  <= S_FLUSH;
						end
					end else begin
						acc_code_q[acc_len_q[BW-1:0]] <= byte_q[j_q];
						acc_len_q <= acc_len_q + 1'b1;
						k_q       <= '0;
						state_q   <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						if (can_post) begin
							pend_v_q <= 1'b1;
							pend_q   <= '{kind: event_kind,
								symbol: (event_kind == KIND_SYM) ? rd_q[CW+LW +: 8] : 8'd0,
								last: 1'b0};
							if (event_kind == KIND_SYM) begin
								acc_code_q <= '0;
								acc_len_q  <= '0;
								j_q        <= j_q + 1'b1;
								state_q    <= (j_q == 3'd7) ? S_FLUSH : S_BIT;
							end else begin
								halted_q <= 1'b1;
								state_q  <= S_FLUSH;
							end
						end
					end else if ({1'b0, k_q} + 1'b1 < fill_q) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_READ;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= (j_q == 3'd7) ? S_FLUSH : S_BIT;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (!res_full) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

### design/hsd_checker.sv
// Port-level checks for the Huffman stream decoder, bound to the top level.
// Depends on hsd_pkg and huffman_stream_decoder.
module hsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] kind,
	input logic [7:0] symbol,
	input logic       last
);
	import hsd_pkg::*;

	// no undefined kind shown
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == KIND_SYM || kind == KIND_END || kind == KIND_ERR))
		else $error("undefined result kind");

	// symbol is zero unless a decoded symbol
	a_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_SYM) |-> symbol == 8'd0)
		else $error("nonzero symbol on end or error");

	// end and error always close the byte
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_SYM) |-> last)
		else $error("end or error result without last");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(symbol) && $stable(last)))
		else $error("result changed while waiting");
endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.kind(kind), .symbol(symbol), .last(last)
);
